// ----- rtl/lsmt_pkg.sv -----
`default_nettype none

package lsmt_pkg;

    localparam int unsigned AccWidth   = 32;
    localparam int unsigned CycWidth   = 16;
    localparam int unsigned LineWidth  = 8;
    localparam int unsigned VisWidth   = 8;
    localparam int unsigned VbWidth    = 6;
    localparam int unsigned ModeWidth  = 2;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 16;

    typedef logic [ModeWidth-1:0] mode_t;

    localparam mode_t MODE_HBLANK = 2'd0;
    localparam mode_t MODE_VBLANK = 2'd1;
    localparam mode_t MODE_OAM    = 2'd2;
    localparam mode_t MODE_VRAM   = 2'd3;

    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_OAM_CYCLES      = 3'd0;
    localparam cfg_idx_t REG_VRAM_CYCLES     = 3'd1;
    localparam cfg_idx_t REG_HBLANK_CYCLES   = 3'd2;
    localparam cfg_idx_t REG_SCANLINE_CYCLES = 3'd3;
    localparam cfg_idx_t REG_VISIBLE_LINES   = 3'd4;
    localparam cfg_idx_t REG_VBLANK_LINES    = 3'd5;

    localparam logic [CycWidth-1:0]  RST_OAM_CYCLES      = 16'd80;
    localparam logic [CycWidth-1:0]  RST_VRAM_CYCLES     = 16'd172;
    localparam logic [CycWidth-1:0]  RST_HBLANK_CYCLES   = 16'd204;
    localparam logic [CycWidth-1:0]  RST_SCANLINE_CYCLES = 16'd456;
    localparam logic [VisWidth-1:0]  RST_VISIBLE_LINES   = 8'd144;
    localparam logic [VbWidth-1:0]   RST_VBLANK_LINES    = 6'd10;

endpackage

`default_nettype wire

// ----- rtl/lcd_scanline_mode_timer_core.sv -----
// Channel   Direction  Ports                                              Transfer
// s_        in         s_tick_cycles[15:0], s_lcd_on                      s_valid & s_ready
// m_        out        m_mode[1:0], m_line_number[7:0], m_draw_line,      m_valid & m_ready
//                      m_frame_done
// cfg_      in         cfg_index[2:0], cfg_data[15:0]                     cfg_valid & cfg_ready
//
// One item per clock sustained while m_ready is high. Input register, then one pass of
// saturating add, threshold compare/subtract and mode/line update into the result register.
// Timer state advances on the cycle the item moves from input to result register.
// A stalled m_ side holds the result register; the input register still accepts one more
// item, after which s_ready drops. cfg_ready is always high.
// aresetn (synchronous) clears both valid flags and timer state, config registers to defaults.

`default_nettype none

module lcd_scanline_mode_timer_core (
    input  wire                                      aclk,
    input  wire                                      aresetn,

    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire  [lsmt_pkg::CycWidth-1:0]            s_tick_cycles,
    input  wire                                      s_lcd_on,

    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic [lsmt_pkg::ModeWidth-1:0]           m_mode,
    output logic [lsmt_pkg::LineWidth-1:0]           m_line_number,
    output logic                                     m_draw_line,
    output logic                                     m_frame_done,

    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire  [lsmt_pkg::CfgIdxWidth-1:0]         cfg_index,
    input  wire  [lsmt_pkg::CfgDataWidth-1:0]        cfg_data
);

    localparam int unsigned AccW  = lsmt_pkg::AccWidth;
    localparam int unsigned CycW  = lsmt_pkg::CycWidth;
    localparam int unsigned LineW = lsmt_pkg::LineWidth;

    // configuration
    logic [CycW-1:0]                   oam_cycles_reg;
    logic [CycW-1:0]                   vram_cycles_reg;
    logic [CycW-1:0]                   hblank_cycles_reg;
    logic [CycW-1:0]                   scanline_cycles_reg;
    logic [lsmt_pkg::VisWidth-1:0]     visible_lines_reg;
    logic [lsmt_pkg::VbWidth-1:0]      vblank_lines_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oam_cycles_reg      <= lsmt_pkg::RST_OAM_CYCLES;
            vram_cycles_reg     <= lsmt_pkg::RST_VRAM_CYCLES;
            hblank_cycles_reg   <= lsmt_pkg::RST_HBLANK_CYCLES;
            scanline_cycles_reg <= lsmt_pkg::RST_SCANLINE_CYCLES;
            visible_lines_reg   <= lsmt_pkg::RST_VISIBLE_LINES;
            vblank_lines_reg    <= lsmt_pkg::RST_VBLANK_LINES;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lsmt_pkg::REG_OAM_CYCLES:      oam_cycles_reg      <= cfg_data;
                lsmt_pkg::REG_VRAM_CYCLES:     vram_cycles_reg     <= cfg_data;
                lsmt_pkg::REG_HBLANK_CYCLES:   hblank_cycles_reg   <= cfg_data;
                lsmt_pkg::REG_SCANLINE_CYCLES: scanline_cycles_reg <= cfg_data;
                lsmt_pkg::REG_VISIBLE_LINES:
                    visible_lines_reg <= cfg_data[lsmt_pkg::VisWidth-1:0];
                lsmt_pkg::REG_VBLANK_LINES:
                    vblank_lines_reg <= cfg_data[lsmt_pkg::VbWidth-1:0];
                default: ;
            endcase
        end
    end

    // handshake / pipeline control
    logic            in_valid_reg;
    logic [CycW-1:0] in_tick_reg;
    logic            in_lcd_on_reg;
    logic            out_free;
    logic            proc_fire;

    assign out_free  = !m_valid || m_ready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tick_reg   <= s_tick_cycles;
            in_lcd_on_reg <= s_lcd_on;
        end
    end

    // timer state
    logic [AccW-1:0]          acc_reg;
    lsmt_pkg::mode_t          mode_reg;
    logic [LineW-1:0]         line_reg;

    logic [AccW-1:0]          acc_next;
    lsmt_pkg::mode_t          mode_next;
    logic [LineW-1:0]         line_next;
    logic                     draw_next;
    logic                     frame_next;

    logic [AccW:0]            sum_wide;
    logic [AccW-1:0]          sum_sat;
    logic [CycW-1:0]          threshold;
    logic                     take;
    logic [LineW:0]           line_inc;
    logic [LineW:0]           total_lines;

    always_comb begin
        sum_wide = {1'b0, acc_reg} + {{(AccW+1-CycW){1'b0}}, in_tick_reg};
        sum_sat  = sum_wide[AccW] ? {AccW{1'b1}} : sum_wide[AccW-1:0];

        case (mode_reg)
            lsmt_pkg::MODE_OAM:    threshold = oam_cycles_reg;
            lsmt_pkg::MODE_VRAM:   threshold = vram_cycles_reg;
            lsmt_pkg::MODE_HBLANK: threshold = hblank_cycles_reg;
            default:               threshold = scanline_cycles_reg;
        endcase

        take        = sum_sat > {{(AccW-CycW){1'b0}}, threshold};
        line_inc    = {1'b0, line_reg} + {{LineW{1'b0}}, 1'b1};
        total_lines = {1'b0, visible_lines_reg}
                    + {{(LineW+1-lsmt_pkg::VbWidth){1'b0}}, vblank_lines_reg};

        acc_next   = acc_reg;
        mode_next  = mode_reg;
        line_next  = line_reg;
        draw_next  = 1'b0;
        frame_next = 1'b0;

        if (!in_lcd_on_reg) begin
            acc_next = '0;
        end else begin
            acc_next = take ? sum_sat - {{(AccW-CycW){1'b0}}, threshold} : sum_sat;
            if (take) begin
                case (mode_reg)
                    lsmt_pkg::MODE_OAM: begin
                        mode_next = lsmt_pkg::MODE_VRAM;
                    end
                    lsmt_pkg::MODE_VRAM: begin
                        mode_next = lsmt_pkg::MODE_HBLANK;
                        draw_next = 1'b1;
                    end
                    lsmt_pkg::MODE_HBLANK: begin
                        line_next = line_inc[LineW-1:0];
                        // a wrapped line of 256 still counts as past the visible area
                        if (line_inc >= {1'b0, visible_lines_reg}) begin
                            mode_next  = lsmt_pkg::MODE_VBLANK;
                            frame_next = 1'b1;
                        end else begin
                            mode_next = lsmt_pkg::MODE_OAM;
                        end
                    end
                    default: begin
                        if (line_inc >= total_lines || line_inc[LineW]) begin
                            line_next = '0;
                            mode_next = lsmt_pkg::MODE_OAM;
                        end else begin
                            line_next = line_inc[LineW-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            mode_reg <= lsmt_pkg::MODE_OAM;
            line_reg <= '0;
        end else if (proc_fire) begin
            acc_reg  <= acc_next;
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            m_mode        <= mode_next;
            m_line_number <= line_next;
            m_draw_line   <= draw_next;
            m_frame_done  <= frame_next;
        end
    end

    // checks
    a_pulse_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_draw_line && m_frame_done))
        else $error("draw_line and frame_done both set");

    a_draw_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_draw_line) |-> (m_mode == lsmt_pkg::MODE_HBLANK))
        else $error("draw_line without entering hblank");

    a_frame_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_mode == lsmt_pkg::MODE_VBLANK))
        else $error("frame_done without entering vblank");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc_fire |=> ($stable(mode_reg) && $stable(line_reg) && $stable(acc_reg)))
        else $error("timer state moved without an item");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_tick_reg)))
        else $error("buffered item lost while result stalled");

endmodule

`default_nettype wire
